// File: src/assert_macros.svh
// Assertion macros for the checker file of the project.
// Each macro takes a label, the clock, the reset (all but ASSERT_ALWAYS_NEXT) and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Checked during reset as well.
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/gis_pkg.sv
// ----------------------------------------------------------------------------
// gis_pkg
// Types and constants of the MPEG-1 sequence header index scanner.
// ----------------------------------------------------------------------------
package gis_pkg;

  localparam int DEF_COUNTER_BITS = 32;
  localparam int OUT_BITS         = 32;
  localparam int WIN_LEN          = 8;
  localparam int FILL_BITS        = 4;
  localparam int SKIP_BITS        = 4;

  localparam logic [7:0] PREFIX_ZERO = 8'h00;
  localparam logic [7:0] PREFIX_ONE  = 8'h01;
  localparam logic [7:0] PIC_CODE    = 8'h00;
  localparam logic [7:0] SEQ_CODE    = 8'hB3;

  localparam logic [SKIP_BITS-1:0] PIC_SKIP = SKIP_BITS'(8);
  localparam logic [SKIP_BITS-1:0] SEQ_SKIP = SKIP_BITS'(13);

  // Picture coding types that count as a frame.
  localparam logic [2:0] CODING_I = 3'd1;
  localparam logic [2:0] CODING_P = 3'd2;
  localparam logic [2:0] CODING_B = 3'd3;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] entry_number;
    logic [OUT_BITS-1:0] frames_before;
    logic [OUT_BITS-1:0] byte_offset;
  } out_word_t;

  // What the start code detector found at the current candidate.
  typedef struct packed {
    logic frame_seen;
    logic seq_seen;
  } scan_event_t;

endpackage

// File: src/gis_stream_if.sv
// ----------------------------------------------------------------------------
// gis_stream_if
// Valid/ready channel that carries one word of a given payload type.
// ----------------------------------------------------------------------------
interface gis_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/gis_detect.sv
// ----------------------------------------------------------------------------
// gis_detect
// Byte window, fill and skip tracking, and start code detection.
// ----------------------------------------------------------------------------
module gis_detect (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           stream_byte,
  input  logic                 stream_start,
  output gis_pkg::scan_event_t scan_event
);
  import gis_pkg::*;

  logic [7:0]           win      [WIN_LEN];
  logic [7:0]           win_next [WIN_LEN];
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;
  logic [SKIP_BITS-1:0] skip;
  logic [SKIP_BITS-1:0] skip_next;

  logic [FILL_BITS-1:0] fill_base;
  logic [SKIP_BITS-1:0] skip_base;
  logic                 full;
  logic                 prefix;
  logic [2:0]           coding;

  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_next[i] = stream_start ? 8'h00 : win[i+1];
    end
    win_next[WIN_LEN-1] = stream_byte;

    fill_base = stream_start ? '0 : fill;
    skip_base = stream_start ? '0 : skip;
    fill_next = (fill_base == FILL_BITS'(WIN_LEN)) ? fill_base : fill_base + 1'b1;
    full      = (fill_next == FILL_BITS'(WIN_LEN));

    prefix = (win_next[0] == PREFIX_ZERO) && (win_next[1] == PREFIX_ZERO) &&
             (win_next[2] == PREFIX_ONE);
    coding = win_next[5][5:3];

    scan_event = '0;
    skip_next  = skip_base;
    if (full) begin
      if (skip_base != '0) begin
        skip_next = skip_base - 1'b1;
      end else if (prefix && (win_next[3] == PIC_CODE)) begin
        scan_event.frame_seen = (coding == CODING_I) || (coding == CODING_P) ||
                                (coding == CODING_B);
        skip_next = PIC_SKIP;
      end else if (prefix && (win_next[3] == SEQ_CODE)) begin
        scan_event.seq_seen = 1'b1;
        skip_next = SEQ_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      skip <= '0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] <= 8'h00;
      end
    end else if (advance) begin
      fill <= fill_next;
      skip <= skip_next;
      for (int i = 0; i < WIN_LEN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end
endmodule

// File: src/gis_index.sv
// ----------------------------------------------------------------------------
// gis_index
// Position, frame and entry counters, and the result register.
// ----------------------------------------------------------------------------
module gis_index #(
  parameter int COUNTER_BITS = gis_pkg::DEF_COUNTER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  stream_start,
  input  gis_pkg::scan_event_t  scan_event,
  input  logic                  out_ready,
  output logic                  out_valid,
  output gis_pkg::out_word_t    out_data
);
  import gis_pkg::*;

  logic [COUNTER_BITS-1:0] position;
  logic [COUNTER_BITS-1:0] frame_count;
  logic [COUNTER_BITS-1:0] entry_count;

  logic [COUNTER_BITS-1:0] pos_base;
  logic [COUNTER_BITS-1:0] frame_base;
  logic [COUNTER_BITS-1:0] entry_base;
  logic [COUNTER_BITS-1:0] offset;
  logic [63:0]             entry_wide;
  logic [63:0]             frame_wide;
  logic [63:0]             offset_wide;

  always_comb begin
    pos_base    = stream_start ? '0 : position;
    frame_base  = stream_start ? '0 : frame_count;
    entry_base  = stream_start ? '0 : entry_count;
    // The start code began seven bytes before the byte that completes the window.
    offset      = pos_base - COUNTER_BITS'(WIN_LEN - 1);
    entry_wide  = 64'(entry_base);
    frame_wide  = 64'(frame_base);
    offset_wide = 64'(offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      frame_count <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      position    <= pos_base + 1'b1;
      frame_count <= frame_base + COUNTER_BITS'(scan_event.frame_seen);
      entry_count <= entry_base + COUNTER_BITS'(scan_event.seq_seen);
      out_valid   <= scan_event.seq_seen;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_event.seq_seen) begin
      out_data.entry_number  <= entry_wide[OUT_BITS-1:0];
      out_data.frames_before <= frame_wide[OUT_BITS-1:0];
      out_data.byte_offset   <= offset_wide[OUT_BITS-1:0];
    end
  end
endmodule

// File: src/mpeg1_gop_index_scanner.sv
// ----------------------------------------------------------------------------
// mpeg1_gop_index_scanner
// Scans an MPEG-1 video stream and emits one index entry per sequence header.
// ----------------------------------------------------------------------------
// The scanner takes one stream byte per cycle and returns, for every sequence
// header start code (00 00 01 B3) outside a skip, a word with the entry
// number, the number of I, P and B pictures seen so far and the byte offset
// of the start code. A byte goes into an input register; from there the
// window compare and the counter updates run in one pass and a sequence
// header lands in the result register. The sustained rate is one byte per
// cycle, set by that single pass; it drops only while a finished result waits
// at the output and the input register is full as well. Picture headers skip
// the next eight candidate positions and sequence headers the next thirteen;
// a byte with stream_start set begins a new stream at position zero with
// cleared counters.
module mpeg1_gop_index_scanner #(
  parameter int COUNTER_BITS = gis_pkg::DEF_COUNTER_BITS
) (
  input logic          clk,
  input logic          rst,
  gis_stream_if.sink   byte_in,
  gis_stream_if.source entry_out
);
  import gis_pkg::*;

  // Input register.
  logic     s1_valid;
  in_word_t s1_word;

  // The pass runs whenever a byte is held and the result register is free or being emptied.
  logic        advance;
  scan_event_t scan_event;

  assign advance       = s1_valid && (!entry_out.valid || entry_out.ready);
  assign byte_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      s1_word <= byte_in.data;
    end
  end

  gis_detect u_detect (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .stream_byte  (s1_word.stream_byte),
    .stream_start (s1_word.stream_start),
    .scan_event   (scan_event)
  );

  gis_index #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_index (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .stream_start (s1_word.stream_start),
    .scan_event   (scan_event),
    .out_ready    (entry_out.ready),
    .out_valid    (entry_out.valid),
    .out_data     (entry_out.data)
  );
endmodule

// File: src/gis_checker.sv
// ----------------------------------------------------------------------------
// gis_checker
// Port level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gis_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gis_pkg::out_word_t out_data
);
  import gis_pkg::*;

  // Bytes accepted since reset, saturating at a full window.
  logic [FILL_BITS-1:0] seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_valid && in_ready && (seen != FILL_BITS'(WIN_LEN))) begin
      seen <= seen + 1'b1;
    end
  end

  `ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_SAME(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)
  `ASSERT_SAME(a_full_window, clk, rst, out_valid, seen == FILL_BITS'(WIN_LEN))
endmodule

bind mpeg1_gop_index_scanner gis_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (byte_in.valid),
  .in_ready  (byte_in.ready),
  .out_valid (entry_out.valid),
  .out_ready (entry_out.ready),
  .out_data  (entry_out.data)
);

// File: test/tb_mpeg1_gop_index_scanner.sv
// ----------------------------------------------------------------------------
// tb_mpeg1_gop_index_scanner
// Self-checking bench for the MPEG-1 sequence header index scanner.
// ----------------------------------------------------------------------------
// A short table of hand-built byte rows comes first. It covers the window
// filling up, a sequence header, a stream restart while a skip is pending, a
// counted picture and a header hidden inside a skip. A long random stream of
// well-formed picture and sequence headers follows, mixed with broken codes,
// noise and rare restarts. Every accepted byte goes through a local scan model
// that predicts the index entries. A checker compares each entry word that
// leaves the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_mpeg1_gop_index_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import gis_pkg::*;

  localparam int CNT_BITS      = DEF_COUNTER_BITS;
  localparam int MAX_GAP       = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int BURST_HEADERS = 30;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 8;
  localparam int TIMEOUT_NS    = 5_000_000;

  // How a directed row is checked: by the scan model, as "no entry" typed in,
  // or against an entry that is typed in.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ENTRY
  } row_check_t;

  typedef struct packed {
    logic [7:0] b;
    logic       s;
    row_check_t check;
    out_word_t  entry;
  } stim_row_t;

  // Directed stream. Rows 0..7 form a sequence header at offset 0 in a fresh
  // stream; no candidate can be tested before the window holds eight bytes.
  // Row 8 restarts the stream while the 13-candidate skip is still running.
  // Rows 8..15 are a B picture header, so one frame is counted and eight
  // candidates are skipped. The sequence header code at position 8 falls
  // inside that skip and must be ignored. The one at position 12 is reported
  // with entry 0, one frame and offset 12.
  stim_row_t directed_rows [28] = '{
    '{8'h00, 1'b1, CHK_NONE,  '0},
    '{8'h00, 1'b0, CHK_NONE,  '0},
    '{8'h01, 1'b0, CHK_NONE,  '0},
    '{8'hB3, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b0, CHK_ENTRY, '{32'd0, 32'd0, 32'd0}},
    '{8'h00, 1'b1, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h01, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'hFF, 1'b0, CHK_MODEL, '0},
    '{8'h18, 1'b0, CHK_MODEL, '0},
    '{8'hFF, 1'b0, CHK_MODEL, '0},
    '{8'hFF, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h01, 1'b0, CHK_MODEL, '0},
    '{8'hB3, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h01, 1'b0, CHK_MODEL, '0},
    '{8'hB3, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'h00, 1'b0, CHK_MODEL, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gis_stream_if #(.payload_t(in_word_t))  byte_if  ();
  gis_stream_if #(.payload_t(out_word_t)) entry_if ();

  mpeg1_gop_index_scanner #(
    .COUNTER_BITS(CNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if.sink),
    .entry_out(entry_if.source)
  );

  // Index entries predicted but not yet seen at the output, oldest first.
  out_word_t expected_entries [$];
  int        mismatch_count = 0;
  int        random_items   = 0;

  // Pacing controls shared between the sender, the receiver and the main flow.
  bit sender_fast   = 1'b0;
  bit receiver_fast = 1'b0;
  bit hold_request  = 1'b0;

  // Scan model state.
  logic [7:0]          scan_window [WIN_LEN];
  logic [FILL_BITS-1:0] scan_fill;
  logic [CNT_BITS-1:0]  scan_pos;
  logic [CNT_BITS-1:0]  frame_total;
  logic [CNT_BITS-1:0]  entry_total;
  logic [SKIP_BITS-1:0] skip_left;

  function automatic void clear_scan_state();
    foreach (scan_window[i]) scan_window[i] = 8'h00;
    scan_fill   = '0;
    scan_pos    = '0;
    frame_total = '0;
    entry_total = '0;
    skip_left   = '0;
  endfunction

  // Takes one accepted byte and returns 1 with the entry it causes, if any.
  // The candidate is the oldest byte of the window, tested once the window is
  // full and no skip is pending.
  function automatic bit scan_byte(input in_word_t w, output out_word_t entry);
    logic [CNT_BITS-1:0] here;
    logic [2:0]          coding;
    entry = '0;
    if (w.stream_start) clear_scan_state();
    for (int i = 0; i < WIN_LEN - 1; i++) scan_window[i] = scan_window[i + 1];
    scan_window[WIN_LEN - 1] = w.stream_byte;
    if (scan_fill < WIN_LEN) scan_fill = scan_fill + 1'b1;
    here     = scan_pos;
    scan_pos = scan_pos + 1'b1;
    if (scan_fill < WIN_LEN) return 1'b0;
    if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
      return 1'b0;
    end
    if (scan_window[0] != PREFIX_ZERO || scan_window[1] != PREFIX_ZERO ||
        scan_window[2] != PREFIX_ONE) return 1'b0;
    if (scan_window[3] == PIC_CODE) begin
      // The coding type sits in bits 5..3 of the second byte after the code.
      // Only I, P and B count, but any picture header starts the skip.
      coding = scan_window[5][5:3];
      if (coding == CODING_I || coding == CODING_P || coding == CODING_B) begin
        frame_total = frame_total + 1'b1;
      end
      skip_left = PIC_SKIP;
      return 1'b0;
    end
    if (scan_window[3] != SEQ_CODE) return 1'b0;
    entry.entry_number  = OUT_BITS'(entry_total);
    entry.frames_before = OUT_BITS'(frame_total);
    entry.byte_offset   = OUT_BITS'(here - CNT_BITS'(WIN_LEN - 1));
    entry_total = entry_total + 1'b1;
    skip_left   = SEQ_SKIP;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [OUT_BITS-1:0] want,
                                      input logic [OUT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

  // Output checker. Values read right after the edge are the ones the edge
  // sampled, since every driver here updates with nonblocking assignments.
  always @(posedge clk) begin : check_entries
    out_word_t want;
    if (!rst && entry_if.valid && entry_if.ready) begin
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected index entry, expected none, got %p", $time, entry_if.data);
        mismatch_count++;
      end else begin
        want = expected_entries.pop_front();
        check_field("entry_number",  want.entry_number,  entry_if.data.entry_number);
        check_field("frames_before", want.frames_before, entry_if.data.frames_before);
        check_field("byte_offset",   want.byte_offset,   entry_if.data.byte_offset);
      end
    end
  end

  // Entry receiver. It draws a wait before every word and, once asked, holds
  // ready low for a long stretch so that results back up into the input.
  initial begin : entry_receiver
    int gap;
    entry_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        gap          = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = receiver_fast ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        entry_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      entry_if.ready <= 1'b1;
      do @(posedge clk); while (!entry_if.valid);
      if ($urandom_range(0, 14) == 0) receiver_fast = !receiver_fast;
    end
  end

  // Offers one byte after a random wait and returns at the edge that takes it.
  // Valid is only lowered when there really is a gap, so a back-to-back byte
  // never sees valid dropped and raised in the same step.
  task automatic offer_byte(input in_word_t w);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.data  <= w;
    byte_if.valid <= 1'b1;
    do @(posedge clk); while (!byte_if.ready);
  endtask

  // Random-part byte: rarely restarts the stream, and feeds the scan model.
  task automatic feed_byte(input logic [7:0] b);
    in_word_t  w;
    out_word_t entry;
    w.stream_byte  = b;
    w.stream_start = ($urandom_range(0, 299) == 0);
    offer_byte(w);
    random_items++;
    if (scan_byte(w, entry)) expected_entries.push_back(entry);
  endtask

  task automatic send_code(input logic [7:0] code);
    feed_byte(PREFIX_ZERO);
    feed_byte(PREFIX_ZERO);
    feed_byte(PREFIX_ONE);
    feed_byte(code);
  endtask

  task automatic send_random_bytes(input int count);
    repeat (count) feed_byte(8'($urandom_range(0, 255)));
  endtask

  // One stretch of the random stream: filler that leans toward zero bytes so
  // that stray prefixes turn up, then a header, a broken code or noise.
  task automatic send_random_stretch();
    int pick;
    repeat ($urandom_range(0, 12)) begin
      feed_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_code(SEQ_CODE);
      send_random_bytes(8);
    end else if (pick < 75) begin
      // Picture header; the random second byte covers every coding type.
      send_code(PIC_CODE);
      send_random_bytes(4);
    end else if (pick < 85) begin
      send_code(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      feed_byte(PREFIX_ZERO);
      feed_byte(PREFIX_ZERO);
      feed_byte(8'($urandom_range(0, 255)));
    end else begin
      send_random_bytes($urandom_range(1, 8));
    end
  endtask

  initial begin : main_flow
    in_word_t  w;
    out_word_t entry;
    bit        got;
    bit        burst_done;
    int        waited;
    burst_done      = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.data    = '0;
    clear_scan_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows. The model always runs so that its state follows the
    // stream; a typed-in row replaces what the model would predict.
    foreach (directed_rows[i]) begin
      w.stream_byte  = directed_rows[i].b;
      w.stream_start = directed_rows[i].s;
      offer_byte(w);
      got = scan_byte(w, entry);
      case (directed_rows[i].check)
        CHK_MODEL: begin
          if (got) expected_entries.push_back(entry);
        end
        CHK_ENTRY: begin
          expected_entries.push_back(directed_rows[i].entry);
        end
        default: begin
        end
      endcase
    end

    // Random stream. Halfway through, a dense run of back-to-back sequence
    // headers meets a long receiver hold-off, so results pile up and the
    // block has to stall its input.
    while (random_items < RANDOM_ITEMS) begin
      if (!burst_done && random_items >= RANDOM_ITEMS / 2) begin
        hold_request = 1'b1;
        sender_fast  = 1'b1;
        repeat (BURST_HEADERS) begin
          send_code(SEQ_CODE);
          send_random_bytes(10);
        end
        sender_fast = 1'b0;
        burst_done  = 1'b1;
      end else begin
        send_random_stretch();
      end
      if ($urandom_range(0, 7) == 0) sender_fast = !sender_fast;
    end
    byte_if.valid <= 1'b0;

    // Drain, then keep watching the output for a tail so that stray words show.
    waited = 0;
    while (expected_entries.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_entries.size() != 0) begin
      $display("%0t: expected %0d more index entries, got none", $time,
               expected_entries.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/gis_pkg.sv
src/gis_stream_if.sv
src/gis_detect.sv
src/gis_index.sv
src/mpeg1_gop_index_scanner.sv
src/gis_checker.sv
test/tb_mpeg1_gop_index_scanner.sv
